// ===== hdl/assert_macros.svh =====
// assertion macros shared by the list rtl
// clocked property checks, masked while reset is asserted (disable iff)
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define CPL_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("list assertion failed");

// condition must never be seen at a clock edge outside reset
`define CPL_NEVER(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("list forbidden condition seen");

`endif

// ===== hdl/cpl_pkg.sv =====
// shared constants and types of the cursor point list
// no dependencies
`default_nettype none

package cpl_pkg;

  localparam int CAPACITY = 16;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = 5;

  localparam logic [31:0] EMPTY_WORD = 32'hBF800000;

  localparam logic [3:0] MODE_APPEND  = 4'd0;
  localparam logic [3:0] MODE_REPLACE = 4'd1;
  localparam logic [3:0] MODE_REMOVE  = 4'd2;
  localparam logic [3:0] MODE_BEGIN   = 4'd3;
  localparam logic [3:0] MODE_END     = 4'd4;
  localparam logic [3:0] MODE_NEXT    = 4'd5;
  localparam logic [3:0] MODE_PRIOR   = 4'd6;
  localparam logic [3:0] MODE_CLEAR   = 4'd7;
  localparam logic [3:0] MODE_READ    = 4'd8;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
  } point_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    point_t           wdata;
    logic             re;
    logic [IDX_W-1:0] raddr;
  } mem_req_t;

endpackage

`default_nettype wire

// ===== hdl/cpl_if.sv =====
// command and response channel interfaces of the cursor point list
// depends on cpl_pkg
`default_nettype none

interface cpl_cmd_if import cpl_pkg::*; ();
  logic        valid;
  logic        ready;
  logic [3:0]  mode;
  logic [31:0] in_x;
  logic [31:0] in_y;
  logic [31:0] in_z;

  modport source (output valid, mode, in_x, in_y, in_z, input ready);
  modport sink (input valid, mode, in_x, in_y, in_z, output ready);
endinterface

interface cpl_rsp_if import cpl_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic                    done_ok;
  logic [31:0]             out_x;
  logic [31:0]             out_y;
  logic [31:0]             out_z;
  logic [CNT_W-1:0]        entry_count;
  logic signed [CNT_W-1:0] cursor_pos;
  logic                    is_empty;
  logic                    is_full;

  modport source (output valid, done_ok, out_x, out_y, out_z, entry_count,
                  cursor_pos, is_empty, is_full, input ready);
  modport sink (input valid, done_ok, out_x, out_y, out_z, entry_count,
                cursor_pos, is_empty, is_full, output ready);
endinterface

`default_nettype wire

// ===== hdl/cpl_point_mem.sv =====
// point storage: one write port, one read port, registered read data
// depends on cpl_pkg
`default_nettype none

module cpl_point_mem import cpl_pkg::*; (
  input  wire logic     clk,
  input  wire mem_req_t req,
  output point_t        rdata
);

  point_t mem [CAPACITY];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rdata <= mem[req.raddr];
    end
  end

endmodule

`default_nettype wire

// ===== hdl/cpl_ctrl.sv =====
// list sequencer: command decode, remove shift loop, cursor read, response register
// depends on cpl_pkg, cpl_if, cpl_point_mem (through the top) and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module cpl_ctrl import cpl_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic [CNT_W-1:0] lim,
  cpl_cmd_if.sink               cmd,
  cpl_rsp_if.source             rsp,
  output mem_req_t              mreq,
  input  wire point_t           rdata
);

  typedef enum logic [2:0] {
    S_IDLE, S_EXEC, S_SHIFT_RD, S_SHIFT_WR, S_READ, S_WAIT
  } state_t;

  state_t           state;
  logic [3:0]       mode_q;
  point_t           pt_q;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] cursor;
  logic [IDX_W-1:0] sh;
  logic             ok;

  logic empty;
  logic in_list;
  logic out_free;
  logic shift_more;
  logic exec_ok;

  assign empty      = (count == '0);
  assign in_list    = !empty && !cursor[CNT_W-1] && (cursor < count);
  assign out_free   = !rsp.valid || rsp.ready;
  assign shift_more = ({1'b0, sh} < count);
  assign cmd.ready  = (state == S_IDLE);

  always_comb begin
    case (mode_q)
      MODE_APPEND:  exec_ok = (count < lim);
      MODE_REPLACE: exec_ok = in_list;
      MODE_REMOVE:  exec_ok = in_list;
      MODE_BEGIN:   exec_ok = !empty;
      MODE_END:     exec_ok = !empty;
      MODE_NEXT:    exec_ok = !empty && (cursor[CNT_W-1] || (cursor + CNT_W'(1) < count));
      MODE_PRIOR:   exec_ok = !empty && !cursor[CNT_W-1] && (cursor != '0);
      MODE_CLEAR:   exec_ok = 1'b1;
      MODE_READ:    exec_ok = !empty;
      default:      exec_ok = 1'b0;
    endcase
  end

  always_comb begin
    mreq = '0;
    case (state)
      S_EXEC: begin
        if (mode_q == MODE_APPEND && count < lim) begin
          mreq.we    = 1'b1;
          mreq.waddr = count[IDX_W-1:0];
          mreq.wdata = pt_q;
        end else if (mode_q == MODE_REPLACE && in_list) begin
          mreq.we    = 1'b1;
          mreq.waddr = cursor[IDX_W-1:0];
          mreq.wdata = pt_q;
        end
      end
      S_SHIFT_RD: begin
        mreq.re    = shift_more;
        mreq.raddr = sh + IDX_W'(1);
      end
      S_SHIFT_WR: begin
        mreq.we    = 1'b1;
        mreq.waddr = sh;
        mreq.wdata = rdata;
      end
      S_READ: begin
        mreq.re    = 1'b1;
        mreq.raddr = cursor[IDX_W-1:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      cursor    <= '1;
      ok        <= 1'b0;
      rsp.valid <= 1'b0;
    end else begin
      if (state == S_WAIT && out_free) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (cmd.valid) begin
            mode_q <= cmd.mode;
            pt_q   <= '{x: cmd.in_x, y: cmd.in_y, z: cmd.in_z};
            state  <= S_EXEC;
          end
        end
        S_EXEC: begin
          ok    <= exec_ok;
          state <= (mode_q == MODE_REMOVE && exec_ok) ? S_SHIFT_RD : S_READ;
          case (mode_q)
            MODE_APPEND: begin
              if (exec_ok) begin
                count  <= count + CNT_W'(1);
                cursor <= count;
              end
            end
            MODE_REMOVE: begin
              if (exec_ok) begin
                count  <= count - CNT_W'(1);
                cursor <= (cursor == count - CNT_W'(1)) ? '0 : cursor;
                sh     <= cursor[IDX_W-1:0];
              end
            end
            MODE_BEGIN: begin
              if (exec_ok) begin
                cursor <= '0;
              end
            end
            MODE_END: begin
              if (exec_ok) begin
                cursor <= count - CNT_W'(1);
              end
            end
            MODE_NEXT: begin
              if (exec_ok) begin
                cursor <= cursor[CNT_W-1] ? '0 : cursor + CNT_W'(1);
              end
            end
            MODE_PRIOR: begin
              if (exec_ok) begin
                cursor <= cursor - CNT_W'(1);
              end
            end
            MODE_CLEAR: begin
              count  <= '0;
              cursor <= '1;
            end
            default: ;
          endcase
        end
        S_SHIFT_RD: begin
          state <= shift_more ? S_SHIFT_WR : S_READ;
        end
        S_SHIFT_WR: begin
          sh    <= sh + IDX_W'(1);
          state <= S_SHIFT_RD;
        end
        S_READ: begin
          state <= S_WAIT;
        end
        S_WAIT: begin
          if (out_free) begin
            rsp.done_ok     <= ok;
            rsp.out_x       <= in_list ? rdata.x : EMPTY_WORD;
            rsp.out_y       <= in_list ? rdata.y : EMPTY_WORD;
            rsp.out_z       <= in_list ? rdata.z : EMPTY_WORD;
            rsp.entry_count <= count;
            rsp.cursor_pos  <= cursor;
            rsp.is_empty    <= empty;
            rsp.is_full     <= (count >= lim);
            state           <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // a read never lands on the entry written in the same cycle
  `CPL_NEVER(a_no_rw_clash, clk, rst, mreq.we && mreq.re && mreq.waddr == mreq.raddr)
  `CPL_ASSERT(a_count_range, clk, rst, count <= CNT_W'(CAPACITY))
  // a nonempty list always has its cursor on a held entry
  `CPL_ASSERT(a_cursor_in_list, clk, rst, empty || in_list)
  `CPL_ASSERT(a_accept_exec, clk, rst, (cmd.valid && cmd.ready) |=> state == S_EXEC)
  `CPL_ASSERT(a_rsp_from_wait, clk, rst, $rose(rsp.valid) |-> $past(state) == S_WAIT)

endmodule

`default_nettype wire

// ===== hdl/cursor_point_list.sv =====
// cursor point list: fixed capacity list of xyz points with a cursor
//
// cmd channel carries one beat per operation: mode plus the x, y and z words
// of a new point (used by append and replace only). rsp channel returns one
// beat per command: ok flag, point at the cursor (0xBF800000 words when none),
// entry count, cursor position (-1 after reset or clear), empty and full flags.
// cfg_wr_en/cfg_wr_data write the capacity limit (reset 16, 0 acts as 1,
// values above the capacity act as the capacity); write only while idle.
// One command is worked on at a time: after accept it passes the execute,
// read and wait states before the response register is loaded. Remove runs
// a shift loop between execute and read that moves each entry behind the
// cursor down one place with one read and one write on the point memory.
// A stalled response waits in the output register: the next command is still
// accepted and runs until its own result is ready, then waits for the slot.
// Reset (rst, synchronous) empties the list, sets the cursor invalid and
// restores the limit; memory contents are not cleared and need no sweep.
// depends on cpl_pkg, cpl_if, cpl_point_mem, cpl_ctrl
`default_nettype none

module cursor_point_list import cpl_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_wr_en,
  input  wire logic [CNT_W-1:0] cfg_wr_data,
  cpl_cmd_if.sink               cmd,
  cpl_rsp_if.source             rsp
);

  logic [CNT_W-1:0] limit_reg;
  logic [CNT_W-1:0] lim;
  mem_req_t         mreq;
  point_t           rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      limit_reg <= CNT_W'(CAPACITY);
    end else if (cfg_wr_en) begin
      limit_reg <= cfg_wr_data;
    end
  end

  always_comb begin
    if (limit_reg == '0) begin
      lim = CNT_W'(1);
    end else if (limit_reg > CNT_W'(CAPACITY)) begin
      lim = CNT_W'(CAPACITY);
    end else begin
      lim = limit_reg;
    end
  end

  cpl_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .lim   (lim),
    .cmd   (cmd),
    .rsp   (rsp),
    .mreq  (mreq),
    .rdata (rdata)
  );

  cpl_point_mem u_mem (
    .clk   (clk),
    .req   (mreq),
    .rdata (rdata)
  );

endmodule

`default_nettype wire
